[rtl/core/mi3_pkg.sv]
// Shared types and constants for the 3x3 matrix inverse unit.
// No dependencies; used by the divider lane and the top level.
`timescale 1ns / 1ps
package mi3_pkg;

	// matrix order and element count
	localparam int DIM      = 3;
	localparam int NUM_ELEM = DIM * DIM;

	// status of one divider lane, sampled by the merging stage
	typedef struct packed {
		logic vld;
		logic sat;
		logic sing;
	} lane_flag_t;

endpackage

[rtl/core/mi3_cof_lane.sv]
// One cofactor lane: cof = m0*m1 - n0*n1, exact, two pipeline stages.
// No package dependencies.
`timescale 1ns / 1ps
module mi3_cof_lane #(
	parameter int W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  logic signed [W-1:0] m0,
	input  logic signed [W-1:0] m1,
	input  logic signed [W-1:0] n0,
	input  logic signed [W-1:0] n1,
	output logic                out_vld,
	output logic signed [2*W:0] cof
);

	logic                  vld_s1, vld_s2;
	logic signed [2*W-1:0] pm_s1, pn_s1;
	logic signed [2*W:0]   cof_s2;

	// valid tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	// stage 1: the two products; stage 2: their difference
	always_ff @(posedge clk) begin
		pm_s1  <= m0 * m1;
		pn_s1  <= n0 * n1;
		cof_s2 <= (2*W+1)'(pm_s1) - (2*W+1)'(pn_s1);
	end

	assign out_vld = vld_s2;
	assign cof     = cof_s2;

endmodule

[rtl/core/mi3_div_lane.sv]
// Pipelined divider lane: round(|cof| * 2^(2F) / |det|) with sign, saturation
// and zero-determinant handling. One quotient bit per stage. Uses mi3_pkg.
`timescale 1ns / 1ps
module mi3_div_lane #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_vld,
	input  logic signed [2*W:0]    cof,
	input  logic signed [3*W+2:0]  det,
	output logic        [W-1:0]    quo,
	output mi3_pkg::lane_flag_t    flags
);
	import mi3_pkg::*;

	localparam int CW = 2 * W + 1;
	localparam int DW = 3 * W + 3;
	localparam int NW = CW + 2 * F;
	localparam int SW = DW + W + 1;
	localparam int RW = ((NW > SW) ? NW : SW) + 1;
	localparam int QW = W + 1;
	localparam logic [QW:0] LIM = (QW + 1)'(1) << (W - 1);

	// entry: magnitudes, sign and overflow pre-check
	logic [CW-1:0] cmag;
	logic [DW-1:0] dmag;
	logic [RW-1:0] nwide;
	logic          ovf;

	always_comb begin
		cmag  = cof[CW-1] ? CW'(-cof) : CW'(cof);
		dmag  = det[DW-1] ? DW'(-det) : DW'(det);
		nwide = RW'(cmag) << (2 * F);
		ovf   = nwide >= (RW'(dmag) << QW);
	end

	logic          vld_s  [0:QW];
	logic [RW-1:0] rem_s  [0:QW];
	logic [QW-1:0] q_s    [0:QW];
	logic [DW-1:0] dm_s   [0:QW];
	logic          neg_s  [0:QW];
	logic          ovf_s  [0:QW];
	logic          sing_s [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= nwide;
		q_s[0]    <= '0;
		dm_s[0]   <= dmag;
		neg_s[0]  <= cof[CW-1] ^ det[DW-1];
		ovf_s[0]  <= ovf;
		sing_s[0] <= (det == '0);
	end

	// restoring stages, quotient bit W down to bit 0
	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [RW-1:0] trial;
		logic          ge;

		always_comb begin
			trial = RW'(dm_s[i]) << (W - i);
			ge    = rem_s[i] >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i+1]  <= ge ? (rem_s[i] - trial) : rem_s[i];
			q_s[i+1]    <= q_s[i] | (ge ? (QW'(1) << (W - i)) : '0);
			dm_s[i+1]   <= dm_s[i];
			neg_s[i+1]  <= neg_s[i];
			ovf_s[i+1]  <= ovf_s[i];
			sing_s[i+1] <= sing_s[i];
		end
	end

	// rounding (ties away from zero) and saturation
	logic          up;
	logic [QW:0]   qr;
	logic [W-1:0]  val;
	logic          sat;

	always_comb begin
		up  = (rem_s[QW] << 1) >= RW'(dm_s[QW]);
		qr  = (QW + 1)'(q_s[QW]) + (QW + 1)'(up);
		val = '0;
		sat = 1'b0;
		if (sing_s[QW]) begin
			val = '0;
		end else if (!neg_s[QW]) begin
			if (ovf_s[QW] || qr >= LIM) begin
				val = {1'b0, {(W-1){1'b1}}};
				sat = 1'b1;
			end else begin
				val = qr[W-1:0];
			end
		end else begin
			if (ovf_s[QW] || qr > LIM) begin
				val = {1'b1, {(W-1){1'b0}}};
				sat = 1'b1;
			end else begin
				val = W'(~qr + (QW + 1)'(1));
			end
		end
	end

	logic         vld_q;
	logic [W-1:0] quo_q;
	logic         sat_q, sing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		quo_q  <= val;
		sat_q  <= sat;
		sing_q <= sing_s[QW];
	end

	assign quo        = quo_q;
	assign flags.vld  = vld_q;
	assign flags.sat  = sat_q;
	assign flags.sing = sing_q;

endmodule

[rtl/core/matrix_inverse_3x3_unit.sv]
// Top level of the 3x3 fixed-point matrix inverse (adjugate / determinant).
// Uses mi3_pkg, mi3_cof_lane (nine cofactor lanes), mi3_div_lane (nine dividers).
//
//  channel | signals                        | transaction
//  --------+--------------------------------+------------------------------
//  input   | start, busy, a00 .. a22        | edge with start=1, busy=0
//  result  | done, inv00 .. inv22, singular,| edge ending the cycle with
//          | saturated                      | done=1
//
// One matrix may enter every cycle; busy is never raised.
// The pipeline depth is set mainly by the divider lanes, which resolve
// one quotient bit per stage (ELEM_WIDTH + 1 stages).
// Reset clears only the valid bits of the pipeline; payload is not reset.
// The receiver cannot stall: each result shows for one cycle with done high.
`timescale 1ns / 1ps
module matrix_inverse_3x3_unit #(
	parameter int ELEM_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [ELEM_WIDTH-1:0] a00,
	input  logic signed [ELEM_WIDTH-1:0] a01,
	input  logic signed [ELEM_WIDTH-1:0] a02,
	input  logic signed [ELEM_WIDTH-1:0] a10,
	input  logic signed [ELEM_WIDTH-1:0] a11,
	input  logic signed [ELEM_WIDTH-1:0] a12,
	input  logic signed [ELEM_WIDTH-1:0] a20,
	input  logic signed [ELEM_WIDTH-1:0] a21,
	input  logic signed [ELEM_WIDTH-1:0] a22,
	output logic                         done,
	output logic signed [ELEM_WIDTH-1:0] inv00,
	output logic signed [ELEM_WIDTH-1:0] inv01,
	output logic signed [ELEM_WIDTH-1:0] inv02,
	output logic signed [ELEM_WIDTH-1:0] inv10,
	output logic signed [ELEM_WIDTH-1:0] inv11,
	output logic signed [ELEM_WIDTH-1:0] inv12,
	output logic signed [ELEM_WIDTH-1:0] inv20,
	output logic signed [ELEM_WIDTH-1:0] inv21,
	output logic signed [ELEM_WIDTH-1:0] inv22,
	output logic                         singular,
	output logic                         saturated
);
	import mi3_pkg::*;

	localparam int W  = ELEM_WIDTH;
	localparam int CW = 2 * W + 1;
	localparam int PW = 2 * W + 1;
	localparam int DW = 3 * W + 3;

	assign busy = 1'b0;

	// input register
	logic                vld_s1;
	logic signed [W-1:0] a_s1 [0:NUM_ELEM-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		a_s1[0] <= a00;
		a_s1[1] <= a01;
		a_s1[2] <= a02;
		a_s1[3] <= a10;
		a_s1[4] <= a11;
		a_s1[5] <= a12;
		a_s1[6] <= a20;
		a_s1[7] <= a21;
		a_s1[8] <= a22;
	end

	// cofactor lanes
	logic                 cof_vld [0:NUM_ELEM-1];
	logic signed [CW-1:0] cof_s3  [0:NUM_ELEM-1];

	for (genvar r = 0; r < DIM; r++) begin : g_cr
		for (genvar c = 0; c < DIM; c++) begin : g_cc
			localparam int R1 = (r + 1) % DIM;
			localparam int R2 = (r + 2) % DIM;
			localparam int C1 = (c + 1) % DIM;
			localparam int C2 = (c + 2) % DIM;

			mi3_cof_lane #(.W(W)) u_cof (
				.clk     (clk),
				.arst_n  (arst_n),
				.in_vld  (vld_s1),
				.m0      (a_s1[R1*DIM+C1]),
				.m1      (a_s1[R2*DIM+C2]),
				.n0      (a_s1[R1*DIM+C2]),
				.n1      (a_s1[R2*DIM+C1]),
				.out_vld (cof_vld[r*DIM+c]),
				.cof     (cof_s3[r*DIM+c])
			);
		end
	end

	// row 0 held alongside the cofactor lanes
	logic signed [W-1:0] a0_s2 [0:DIM-1];
	logic signed [W-1:0] a0_s3 [0:DIM-1];

	always_ff @(posedge clk) begin
		for (int c = 0; c < DIM; c++) begin
			a0_s2[c] <= a_s1[c];
			a0_s3[c] <= a0_s2[c];
		end
	end

	// determinant: split partial products, combine, then sum
	logic                 vld_s4, vld_s5, vld_s6;
	logic signed [PW-1:0] plo_s4  [0:DIM-1];
	logic signed [PW-1:0] phi_s4  [0:DIM-1];
	logic signed [DW-1:0] prod_s5 [0:DIM-1];
	logic signed [DW-1:0] det_s6;
	logic signed [CW-1:0] cof_s4  [0:NUM_ELEM-1];
	logic signed [CW-1:0] cof_s5  [0:NUM_ELEM-1];
	logic signed [CW-1:0] cof_s6  [0:NUM_ELEM-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s4 <= cof_vld[0];
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < DIM; c++) begin
			plo_s4[c]  <= a0_s3[c] * $signed({1'b0, cof_s3[c][W-1:0]});
			phi_s4[c]  <= a0_s3[c] * $signed(cof_s3[c][CW-1:W]);
			prod_s5[c] <= (DW'(phi_s4[c]) <<< W) + DW'(plo_s4[c]);
		end
		det_s6 <= prod_s5[0] + prod_s5[1] + prod_s5[2];
		for (int k = 0; k < NUM_ELEM; k++) begin
			cof_s4[k] <= cof_s3[k];
			cof_s5[k] <= cof_s4[k];
			cof_s6[k] <= cof_s5[k];
		end
	end

	// divider lanes: inv[r][c] = cof[c][r] / det
	logic       [W-1:0] quo   [0:NUM_ELEM-1];
	lane_flag_t         flags [0:NUM_ELEM-1];

	for (genvar r = 0; r < DIM; r++) begin : g_dr
		for (genvar c = 0; c < DIM; c++) begin : g_dc
			mi3_div_lane #(.W(W), .F(FRAC_BITS)) u_div (
				.clk    (clk),
				.arst_n (arst_n),
				.in_vld (vld_s6),
				.cof    (cof_s6[c*DIM+r]),
				.det    (det_s6),
				.quo    (quo[r*DIM+c]),
				.flags  (flags[r*DIM+c])
			);
		end
	end

	// merge: gather lane results and combine the flags
	logic         any_sat;
	logic         done_q, singular_q, saturated_q;
	logic [W-1:0] inv_q [0:NUM_ELEM-1];

	always_comb begin
		any_sat = 1'b0;
		for (int k = 0; k < NUM_ELEM; k++) begin
			any_sat = any_sat | flags[k].sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= flags[0].vld;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_ELEM; k++) begin
			inv_q[k] <= quo[k];
		end
		singular_q  <= flags[0].sing;
		saturated_q <= any_sat;
	end

	assign done      = done_q;
	assign inv00     = $signed(inv_q[0]);
	assign inv01     = $signed(inv_q[1]);
	assign inv02     = $signed(inv_q[2]);
	assign inv10     = $signed(inv_q[3]);
	assign inv11     = $signed(inv_q[4]);
	assign inv12     = $signed(inv_q[5]);
	assign inv20     = $signed(inv_q[6]);
	assign inv21     = $signed(inv_q[7]);
	assign inv22     = $signed(inv_q[8]);
	assign singular  = singular_q;
	assign saturated = saturated_q;

endmodule

[verif/matrix_inverse_3x3_unit_tb.sv]
// Self-checking testbench for matrix_inverse_3x3_unit: random and directed matrices,
// exact big-integer prediction of the adjugate / determinant quotient.
// Depends on mi3_pkg and the matrix_inverse_3x3_unit RTL.
`timescale 1ns / 1ps

// Holds predicted inverses in arrival order and compares results against them
class inverse_scoreboard;
	typedef struct {
		logic signed [31:0] elem [9];
		logic               sing;
		logic               sat;
	} inverse_t;

	inverse_t pending[$];
	int       mismatches;

	// Exact inverse: cofactors and determinant in wide integers, rounded quotient
	function void note_matrix(logic signed [31:0] m [9]);
		logic signed [191:0] a [3][3];
		logic signed [191:0] cof [3][3];
		logic signed [191:0] det, num, dmag, q, rem, lim;
		logic                neg;
		inverse_t            res;
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				a[r][c] = m[r * 3 + c];
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				cof[r][c] = a[(r + 1) % 3][(c + 1) % 3] * a[(r + 2) % 3][(c + 2) % 3]
					- a[(r + 1) % 3][(c + 2) % 3] * a[(r + 2) % 3][(c + 1) % 3];
		det = a[0][0] * cof[0][0] + a[0][1] * cof[0][1] + a[0][2] * cof[0][2];
		res.sat = 0;
		res.sing = (det == 0);
		dmag = (det < 0) ? -det : det;
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++) begin
				if (res.sing) begin
					res.elem[r * 3 + c] = 0;
					continue;
				end
				num = cof[c][r];
				neg = (num < 0) != (det < 0);
				num = ((num < 0) ? -num : num) <<< 32;
				q = num / dmag;
				rem = num % dmag;
				// ties round away from zero
				if ((rem <<< 1) >= dmag)
					q = q + 1;
				if (q == 0)
					neg = 0;
				lim = neg ? 192'sd2147483648 : 192'sd2147483647;
				if (q > lim) begin
					res.sat = 1;
					q = lim;
				end
				res.elem[r * 3 + c] = neg ? -q[31:0] : q[31:0];
			end
		pending.push_back(res);
	endfunction

	function void check_result(logic signed [31:0] got [9], logic sing, logic sat);
		inverse_t exp;
		bit       bad;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result with no matrix outstanding", $realtime);
			return;
		end
		exp = pending.pop_front();
		bad = (sing !== exp.sing) || (sat !== exp.sat);
		for (int k = 0; k < 9; k++)
			if (got[k] !== exp.elem[k])
				bad = 1;
		if (bad) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: inverse differs, sing %0b/%0b sat %0b/%0b (exp/got)",
					$realtime, exp.sing, sing, exp.sat, sat);
				for (int k = 0; k < 9; k++)
					$display("  inv%0d%0d exp %h got %h", k / 3, k % 3, exp.elem[k], got[k]);
			end
		end
	endfunction
endclass

module matrix_inverse_3x3_unit_tb;
	import mi3_pkg::*;

	localparam int LATENCY = 42;

	logic               clk, arst_n, start, busy, done, singular, saturated;
	logic signed [31:0] a [NUM_ELEM];
	logic signed [31:0] inv [NUM_ELEM];
	logic signed [31:0] got [9];
	logic signed [31:0] m [9];
	inverse_scoreboard  sb;

	matrix_inverse_3x3_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.a00(a[0]), .a01(a[1]), .a02(a[2]), .a10(a[3]), .a11(a[4]), .a12(a[5]),
		.a20(a[6]), .a21(a[7]), .a22(a[8]),
		.done(done),
		.inv00(inv[0]), .inv01(inv[1]), .inv02(inv[2]), .inv10(inv[3]), .inv11(inv[4]),
		.inv12(inv[5]), .inv20(inv[6]), .inv21(inv[7]), .inv22(inv[8]),
		.singular(singular), .saturated(saturated)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// result side: sample at the rising edge that ends the done cycle
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			for (int k = 0; k < 9; k++)
				got[k] = inv[k];
			sb.check_result(got, singular, saturated);
		end
	end

	// one transaction; start stays high across back-to-back matrices
	task automatic send_matrix(input logic signed [31:0] mat [9], input bit last);
		int gap;
		gap = (last || $urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 0;
		start <= 1;
		for (int k = 0; k < 9; k++)
			a[k] <= mat[k];
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		sb.note_matrix(mat);
		@(negedge clk);
		if (gap > 0 || last) begin
			start <= 0;
			repeat (gap)
				@(negedge clk);
		end
	endtask

	// random element: full range, small Q16.16 values, extremes or raw values within +/-0x200
	function automatic logic signed [31:0] rand_elem(int kind);
		case (kind)
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
			2: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
			default: return $signed($urandom_range(0, 32'h0000_0400)) - 32'sh200;
		endcase
	endfunction

	initial begin
		sb = new();
		start = 0;
		arst_n = 0;
		for (int k = 0; k < 9; k++)
			a[k] = 0;
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: identity, scaled, zero, singular rows, extremes, tiny det
		for (int t = 0; t < 14; t++) begin
			for (int k = 0; k < 9; k++)
				m[k] = 0;
			case (t)
				0: begin m[0] = 32'sh10000; m[4] = 32'sh10000; m[8] = 32'sh10000; end
				1: begin m[0] = 32'sh20000; m[4] = -32'sh8000; m[8] = 32'sh30000; end
				2: ;
				3: for (int k = 0; k < 9; k++) m[k] = k + 1;
				4: for (int k = 0; k < 9; k++) m[k] = 32'sh8000_0000;
				5: for (int k = 0; k < 9; k++) m[k] = 32'sh7fff_ffff;
				6: begin m[0] = 1; m[4] = 1; m[8] = 1; end
				7: begin m[0] = 32'sh8000_0000; m[4] = 32'sh7fff_ffff; m[8] = -1; end
				8: begin m[0] = 32'sh7fff_ffff; m[4] = 32'sh7fff_ffff; m[8] = 32'sh7fff_ffff; end
				9: begin m[2] = 32'sh10000; m[4] = 32'sh10000; m[6] = 32'sh10000; end
				10: begin m[0] = 3; m[1] = 1; m[4] = 32'sh10000; m[8] = 32'sh10000; end
				11: begin m[0] = -1; m[4] = 32'sh8000_0000; m[8] = 32'sh8000_0000; end
				12: for (int k = 0; k < 9; k++) m[k] = -1;
				default: begin m[0] = 32'sh18000; m[4] = 32'sh18000; m[8] = 32'sh18000; end
			endcase
			send_matrix(m, 0);
		end

		// random: mostly well-conditioned, with full-range and singular mixes
		for (int n = 0; n < 1900; n++) begin
			int kind;
			kind = $urandom_range(0, 9);
			for (int k = 0; k < 9; k++)
				m[k] = rand_elem(kind < 4 ? 1 : (kind < 6 ? 0 : (kind < 7 ? 2 : 3)));
			if ($urandom_range(0, 15) == 0)
				for (int k = 0; k < 3; k++)
					m[6 + k] = m[k];
			send_matrix(m, n == 1899);
		end

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY)
			@(posedge clk);
		if (sb.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#2ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
